/* design/c2mp_pkg.sv */
package c2mp_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int RES_W = 16;

   localparam int ANG_STAGES = 31;
   localparam int FRAC_SHIFT = 61 - SAMPLE_WIDTH;
   localparam int XY_W = 64;
   localparam int ANG_W = 34;

   localparam int PH_LAT = ANG_STAGES + 2;
   localparam int MAG_LAT = SAMPLE_WIDTH + 3;
   localparam int PIPE_LAT = (PH_LAT > MAG_LAT) ? PH_LAT : MAG_LAT;

   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
   localparam logic signed [ANG_W-1:0] ROUND_HALF = 34'sh0_0000_8000;

   // Arctangent of 2^-i in units of pi/2^31.
   localparam logic [31:0] ATAN_TAB [ANG_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001
   };

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

endpackage

/* design/c2mp_cordic.sv */
module c2mp_cordic (
   input  logic                                        clock,
   input  logic                                        reset,
   input  c2mp_pkg::pipe_ctl_type                      ctl,
   input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0]    real_in,
   input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0]    imag_in,
   output logic                                        valid_out,
   output logic signed [c2mp_pkg::RES_W-1:0]           phase
);

   localparam int XW = c2mp_pkg::XY_W;
   localparam int AW = c2mp_pkg::ANG_W;
   localparam int NS = c2mp_pkg::ANG_STAGES;
   localparam int LAT = c2mp_pkg::PIPE_LAT;
   localparam int PAD = c2mp_pkg::PIPE_LAT - c2mp_pkg::PH_LAT;

   logic signed [XW-1:0] x_ff [NS+1];
   logic signed [XW-1:0] y_ff [NS+1];
   logic signed [AW-1:0] ang_ff [NS+1];
   logic signed [c2mp_pkg::RES_W-1:0] ph_ff [PAD+1];
   logic [LAT-1:0] vld_ff;

   logic signed [XW-1:0] re_w, im_w;
   logic signed [XW-1:0] x0_in, y0_in;
   logic signed [AW-1:0] a0_in;

   assign re_w = XW'(real_in);
   assign im_w = XW'(imag_in);

   // Fold the left half plane into the right half plane by a quarter turn.
   always_comb begin
      x0_in = re_w;
      y0_in = im_w;
      a0_in = '0;
      if (re_w < 0) begin
         if (im_w >= 0) begin
            x0_in = im_w;
            y0_in = -re_w;
            a0_in = c2mp_pkg::QUARTER_TURN;
         end else begin
            x0_in = -im_w;
            y0_in = re_w;
            a0_in = -c2mp_pkg::QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         x_ff[0]   <= x0_in <<< c2mp_pkg::FRAC_SHIFT;
         y_ff[0]   <= y0_in <<< c2mp_pkg::FRAC_SHIFT;
         ang_ff[0] <= a0_in;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic signed [XW-1:0] xs, ys, x_in, y_in;
      logic signed [AW-1:0] step, ang_in;

      assign xs   = x_ff[i] >>> i;
      assign ys   = y_ff[i] >>> i;
      assign step = AW'(c2mp_pkg::ATAN_TAB[i]);

      always_comb begin
         x_in   = x_ff[i];
         y_in   = y_ff[i];
         ang_in = ang_ff[i];
         if (y_ff[i] > 0) begin
            x_in   = x_ff[i] + ys;
            y_in   = y_ff[i] - xs;
            ang_in = ang_ff[i] + step;
         end else if (y_ff[i] < 0) begin
            x_in   = x_ff[i] - ys;
            y_in   = y_ff[i] + xs;
            ang_in = ang_ff[i] - step;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            ang_ff[i+1] <= ang_in;
         end
      end
   end

   logic signed [AW-1:0] rnd;
   logic signed [AW-17:0] quo;
   logic signed [c2mp_pkg::RES_W-1:0] ph_in;

   assign rnd = ang_ff[NS] + c2mp_pkg::ROUND_HALF;
   assign quo = signed'(rnd[AW-1:16]);

   always_comb begin
      if (quo > 32767) begin
         ph_in = 16'sh7FFF;
      end else if (quo < -32768) begin
         ph_in = 16'sh8000;
      end else begin
         ph_in = quo[c2mp_pkg::RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         ph_ff[0] <= ph_in;
         for (int k = 1; k <= PAD; k++) begin
            ph_ff[k] <= ph_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.en) begin
         vld_ff <= {vld_ff[LAT-2:0], ctl.valid};
      end
   end

   assign valid_out = vld_ff[LAT-1];
   assign phase     = ph_ff[PAD];

   a_fold_right_half: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> x_ff[0] >= 0)
      else $error("Folded sample left the right half plane.");

   a_x_stays_positive: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] |-> x_ff[NS] >= 0)
      else $error("Rotated x went negative.");

endmodule

/* design/c2mp_sqrt.sv */
module c2mp_sqrt (
   input  logic                                        clock,
   input  logic                                        reset,
   input  c2mp_pkg::pipe_ctl_type                      ctl,
   input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0]    real_in,
   input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0]    imag_in,
   output logic                                        valid_out,
   output logic [c2mp_pkg::RES_W-1:0]                  magnitude
);

   localparam int SW = c2mp_pkg::SAMPLE_WIDTH;
   localparam int DW = 2 * c2mp_pkg::SAMPLE_WIDTH;
   localparam int RW = c2mp_pkg::SAMPLE_WIDTH + 3;
   localparam int MW = 33;
   localparam int LAT = c2mp_pkg::PIPE_LAT;
   localparam int PAD = c2mp_pkg::PIPE_LAT - c2mp_pkg::MAG_LAT;

   logic [SW-1:0] are, aim;
   logic [DW-1:0] sq_re_ff, sq_im_ff;
   logic [DW-1:0] rad_ff [SW+1];
   logic [SW-1:0] root_ff [SW+1];
   logic [RW-1:0] rem_ff [SW+1];
   logic [c2mp_pkg::RES_W-1:0] mag_ff [PAD+1];
   logic [LAT-1:0] vld_ff;

   assign are = real_in[SW-1] ? SW'(-real_in) : SW'(real_in);
   assign aim = imag_in[SW-1] ? SW'(-imag_in) : SW'(imag_in);

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         sq_re_ff  <= DW'(are) * DW'(are);
         sq_im_ff  <= DW'(aim) * DW'(aim);
         rad_ff[0] <= sq_re_ff + sq_im_ff;
         root_ff[0] <= '0;
         rem_ff[0]  <= '0;
      end
   end

   // Restoring square root, one root bit per stage.
   for (genvar k = 0; k < SW; k++) begin : g_digit
      logic [RW-1:0] rem_sh, trial, rem_in;
      logic [SW-1:0] root_in;

      assign rem_sh = {rem_ff[k][RW-3:0], rad_ff[k][DW-1 -: 2]};
      assign trial  = RW'({root_ff[k], 2'b01});

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[k][SW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[k][SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rad_ff[k+1]  <= rad_ff[k] << 2;
            root_ff[k+1] <= root_in;
            rem_ff[k+1]  <= rem_in;
         end
      end
   end

   logic [MW-1:0] rounded;
   logic [c2mp_pkg::RES_W-1:0] mag_in;

   assign rounded = MW'(root_ff[SW]) + MW'(rem_ff[SW] > RW'(root_ff[SW]));
   assign mag_in  = (rounded > MW'(16'hFFFF)) ? 16'hFFFF : rounded[c2mp_pkg::RES_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         mag_ff[0] <= mag_in;
         for (int j = 1; j <= PAD; j++) begin
            mag_ff[j] <= mag_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.en) begin
         vld_ff <= {vld_ff[LAT-2:0], ctl.valid};
      end
   end

   assign valid_out = vld_ff[LAT-1];
   assign magnitude = mag_ff[PAD];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SW+1] |-> rem_ff[SW] <= RW'({root_ff[SW], 1'b0}))
      else $error("Square root remainder exceeds twice the root.");

endmodule

/* design/complex_to_magnitude_phase.sv */
// Rectangular to polar converter. Each beat carries one complex sample with
// signed real and imaginary parts; the matching result beat carries the
// magnitude, rounded to nearest from an exact integer square root, and the
// phase atan2(imag, real) in signed units of pi/32768, with plus pi
// saturated to 32767 and a zero sample giving phase 0. A new sample is
// taken every clock while req_stall is low, and each result passes through
// the quadrant fold, the 31 CORDIC rotation stages and the final rounding
// stage; the square root pipeline runs alongside and is padded to the same
// depth. When a result is held by rsp_stall, the whole pipeline freezes and
// req_stall is raised in the same cycle.
module complex_to_magnitude_phase (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0]    req_real_in,
   input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0]    req_imag_in,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [c2mp_pkg::RES_W-1:0]                  rsp_magnitude,
   output logic signed [c2mp_pkg::RES_W-1:0]           rsp_phase
);

   c2mp_pkg::pipe_ctl_type ctl;
   logic mag_valid, ph_valid;

   assign ctl.en    = !(rsp_valid && rsp_stall);
   assign ctl.valid = req_valid;
   assign req_stall = !ctl.en;

   c2mp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .real_in   (req_real_in),
      .imag_in   (req_imag_in),
      .valid_out (mag_valid),
      .magnitude (rsp_magnitude)
   );

   c2mp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .real_in   (req_real_in),
      .imag_in   (req_imag_in),
      .valid_out (ph_valid),
      .phase     (rsp_phase)
   );

   assign rsp_valid = ph_valid;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      mag_valid == ph_valid)
      else $error("Magnitude and phase lanes are out of step.");

   a_zero_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_magnitude == '0) |-> rsp_phase == '0)
      else $error("Zero magnitude beat carries a nonzero phase.");

endmodule
